@@ rtl/rfp_pkg.sv @@
// Shared types and constants for the ranging frame parser.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package rfp_pkg;

    // Field widths fixed by the frame format
    localparam int BYTE_W         = 8;
    localparam int RANGE_W        = 16;
    localparam int LEN_W          = 6;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 8;
    localparam int RANGE_BYTES    = 6;

    // Payload length limits
    localparam int RFP_MAX_PAYLOAD = 32;
    localparam int MIN_PAYLOAD     = 9;
    localparam int LENGTH_RESET    = 9;

    // Payload byte positions of interest
    localparam int TAG_POS        = 0;
    localparam int RANGE_FIRST    = 3;
    localparam int RANGE_LAST     = 8;

    typedef enum logic [2:0] {
        PH_HEAD_A  = 3'd0,
        PH_HEAD_B  = 3'd1,
        PH_HEAD_C  = 3'd2,
        PH_PAYLOAD = 3'd3,
        PH_TRAIL_A = 3'd4,
        PH_TRAIL_B = 3'd5
    } t_phase;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HEADER_A  = 3'd0,
        REG_HEADER_B  = 3'd1,
        REG_HEADER_C  = 3'd2,
        REG_TRAILER_A = 3'd3,
        REG_TRAILER_B = 3'd4,
        REG_LENGTH    = 3'd5
    } t_cfg_index;

    typedef struct packed {
        logic [BYTE_W-1:0] header_byte_a;
        logic [BYTE_W-1:0] header_byte_b;
        logic [BYTE_W-1:0] header_byte_c;
        logic [BYTE_W-1:0] trailer_byte_a;
        logic [BYTE_W-1:0] trailer_byte_b;
        logic [LEN_W-1:0]  payload_length;
    } t_cfg;

    typedef struct packed {
        logic [BYTE_W-1:0] rx_byte;
    } t_rx_item;

    typedef struct packed {
        logic [BYTE_W-1:0]  tag_id;
        logic [RANGE_W-1:0] range_one;
        logic [RANGE_W-1:0] range_two;
        logic [RANGE_W-1:0] range_three;
    } t_result;

endpackage

`default_nettype wire

@@ rtl/rfp_stream_if.sv @@
// Valid/ready stream channel used for the byte input and the result output.
// Payload type is a parameter; defaults come from rfp_pkg.
`default_nettype none

interface rfp_stream_if
    import rfp_pkg::*;
#(
    parameter type t_payload = t_rx_item
) ();

    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);

endinterface

`default_nettype wire

@@ rtl/ranging_frame_parser.sv @@
// Top level of the ranging frame parser: config registers, frame FSM, result buffer.
// Depends on rfp_pkg, rfp_stream_if, rfp_cfg_regs, rfp_frame_fsm and rfp_out_buf.
`default_nettype none

// One received byte is taken per cycle on i_rx while i_rx.ready is high; the parser
// hunts for the three header bytes, counts payload_length payload bytes (clamped
// to 9..MAX_PAYLOAD), then checks the two trailer bytes. A mismatching header or
// trailer byte sends it back to hunting, and that byte is not tried again as a
// first header byte. A good frame yields one item on o_result: the tag byte and
// three little-endian 16-bit ranges in centimetres from payload bytes 3..8. The
// result is registered on the second trailer byte, into the buffer's output stage,
// or its skid stage while an earlier result waits. A two-deep result buffer keeps
// i_rx.ready high unless two results are waiting. Write the configuration registers
// only while the stream is idle; writes to unknown indexes are dropped.

module ranging_frame_parser
    import rfp_pkg::*;
#(
    parameter int MAX_PAYLOAD = RFP_MAX_PAYLOAD
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    rfp_stream_if.sink                 i_rx,
    rfp_stream_if.source               o_result
);

    t_cfg    cfg;
    logic    rx_take;
    logic    res_valid;
    t_result res_data;
    logic    buf_space;
    t_result out_data;

    rfp_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // Accept a byte whenever the skid stage is free
    assign i_rx.ready = buf_space;
    assign rx_take    = i_rx.valid && buf_space;

    rfp_frame_fsm #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_frame_fsm (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_take      (rx_take),
        .i_rx_byte   (i_rx.payload.rx_byte),
        .o_res_valid (res_valid),
        .o_res       (res_data)
    );

    rfp_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (res_valid),
        .i_data  (res_data),
        .o_space (buf_space),
        .o_valid (o_result.valid),
        .o_data  (out_data),
        .i_ready (o_result.ready)
    );

    assign o_result.payload = out_data;

endmodule

`default_nettype wire

@@ rtl/rfp_cfg_regs.sv @@
// Configuration register file of the ranging frame parser.
// Depends on rfp_pkg for the register index codes and the t_cfg struct.
`default_nettype none

module rfp_cfg_regs
    import rfp_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                       o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg                <= '0;
            r_cfg.payload_length <= LEN_W'(LENGTH_RESET);
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                REG_HEADER_A:  r_cfg.header_byte_a  <= i_cfg_data;
                REG_HEADER_B:  r_cfg.header_byte_b  <= i_cfg_data;
                REG_HEADER_C:  r_cfg.header_byte_c  <= i_cfg_data;
                REG_TRAILER_A: r_cfg.trailer_byte_a <= i_cfg_data;
                REG_TRAILER_B: r_cfg.trailer_byte_b <= i_cfg_data;
                REG_LENGTH:    r_cfg.payload_length <= i_cfg_data[LEN_W-1:0];
                default: begin
                    // drop writes to unknown indexes
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

@@ rtl/rfp_frame_fsm.sv @@
// Frame state machine: header hunt, payload capture, trailer check.
// Depends on rfp_pkg for the phase enum, t_cfg and t_result.
`default_nettype none

module rfp_frame_fsm
    import rfp_pkg::*;
#(
    parameter int MAX_PAYLOAD = RFP_MAX_PAYLOAD
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_cfg              i_cfg,
    input  wire logic              i_take,
    input  wire logic [BYTE_W-1:0] i_rx_byte,
    output logic                   o_res_valid,
    output t_result                o_res
);

    localparam int IDX_W = $clog2(MAX_PAYLOAD);

    t_phase             r_phase, n_phase;
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic [BYTE_W-1:0]  r_tag, n_tag;
    logic [BYTE_W-1:0]  r_range [RANGE_BYTES];
    logic [BYTE_W-1:0]  n_range [RANGE_BYTES];

    logic [LEN_W-1:0]   eff_len;
    logic [LEN_W-1:0]   idx_inc;
    logic [LEN_W-1:0]   idx_ext;

    // Clamp the configured length into the supported range
    always_comb begin
        if (i_cfg.payload_length < LEN_W'(MIN_PAYLOAD)) begin
            eff_len = LEN_W'(MIN_PAYLOAD);
        end else if (i_cfg.payload_length > LEN_W'(MAX_PAYLOAD)) begin
            eff_len = LEN_W'(MAX_PAYLOAD);
        end else begin
            eff_len = i_cfg.payload_length;
        end
    end

    assign idx_ext = LEN_W'(r_idx);
    assign idx_inc = idx_ext + LEN_W'(1);

    // Next state
    always_comb begin
        n_phase = r_phase;
        n_idx   = r_idx;
        if (i_take) begin
            unique case (r_phase)
                PH_HEAD_B: begin
                    n_phase = (i_rx_byte == i_cfg.header_byte_b) ? PH_HEAD_C : PH_HEAD_A;
                end
                PH_HEAD_C: begin
                    n_phase = (i_rx_byte == i_cfg.header_byte_c) ? PH_PAYLOAD : PH_HEAD_A;
                    n_idx   = '0;
                end
                PH_PAYLOAD: begin
                    if (idx_inc >= eff_len) begin
                        n_phase = PH_TRAIL_A;
                        n_idx   = '0;
                    end else begin
                        n_idx   = idx_inc[IDX_W-1:0];
                    end
                end
                PH_TRAIL_A: begin
                    n_phase = (i_rx_byte == i_cfg.trailer_byte_a) ? PH_TRAIL_B : PH_HEAD_A;
                end
                PH_TRAIL_B: begin
                    n_phase = PH_HEAD_A;
                end
                default: begin
                    n_phase = (i_rx_byte == i_cfg.header_byte_a) ? PH_HEAD_B : PH_HEAD_A;
                end
            endcase
        end
    end

    // Outputs: payload capture and result strobe
    always_comb begin
        n_tag   = r_tag;
        n_range = r_range;
        if (i_take && r_phase == PH_PAYLOAD) begin
            if (idx_ext == LEN_W'(TAG_POS)) begin
                n_tag = i_rx_byte;
            end
            for (int k = 0; k < RANGE_BYTES; k++) begin
                if (idx_ext == LEN_W'(RANGE_FIRST + k)) begin
                    n_range[k] = i_rx_byte;
                end
            end
        end
        o_res_valid = i_take && (r_phase == PH_TRAIL_B)
                      && (i_rx_byte == i_cfg.trailer_byte_b);
        o_res.tag_id      = r_tag;
        o_res.range_one   = {r_range[1], r_range[0]};
        o_res.range_two   = {r_range[3], r_range[2]};
        o_res.range_three = {r_range[5], r_range[4]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEAD_A;
            r_idx   <= '0;
            r_tag   <= '0;
            for (int k = 0; k < RANGE_BYTES; k++) begin
                r_range[k] <= '0;
            end
        end else begin
            r_phase <= n_phase;
            r_idx   <= n_idx;
            r_tag   <= n_tag;
            r_range <= n_range;
        end
    end

endmodule

`default_nettype wire

@@ rtl/rfp_out_buf.sv @@
// Result register with a skid stage, so the input side sees a registered ready.
// Depends on rfp_pkg for t_result.
`default_nettype none

module rfp_out_buf
    import rfp_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_valid,
    input  wire t_result i_data,
    output logic         o_space,
    output logic         o_valid,
    output t_result      o_data,
    input  wire logic    i_ready
);

    logic    r_out_valid, r_skid_valid;
    t_result r_out_data, r_skid_data;
    logic    take;

    assign take    = r_out_valid && i_ready;
    assign o_space = !r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || take) begin
            // output slot frees up: advance skid first, else new item
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= i_valid;
            end else begin
                r_out_valid  <= i_valid;
            end
        end else if (i_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || take) begin
            if (r_skid_valid) begin
                r_out_data  <= r_skid_data;
                r_skid_data <= i_data;
            end else begin
                r_out_data  <= i_data;
            end
        end else if (i_valid) begin
            r_skid_data <= i_data;
        end
    end

endmodule

`default_nettype wire

@@ verif/ranging_frame_parser_tb.sv @@
// Self-checking testbench for ranging_frame_parser: directed frames, then random frame traffic.
// Depends on rfp_pkg, rfp_stream_if and the ranging_frame_parser RTL; needs nothing else.

module ranging_frame_parser_tb;
    import rfp_pkg::*;

    // Register indexes that decode to nothing; writes to them must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

    localparam int ITEMS_TOTAL       = 2000;
    localparam int NUM_PHASES        = 8;
    localparam int PHASE_BYTES       = ITEMS_TOTAL / NUM_PHASES;
    localparam int FULL_FRAME        = 64;
    localparam int SETTLE_CYCLES     = 4;
    localparam int LONG_HOLD_CYCLES  = 300;
    localparam int CYCLE_LIMIT       = 500000;

    typedef enum logic [1:0] {ROW_BYTE, ROW_CFG, ROW_SETTLE} t_row_kind;

    typedef struct packed {
        t_row_kind            kind;
        logic [CFG_IDX_W-1:0] index;
        logic [7:0]           value;
        logic                 typed;
        t_result              want;
    } t_row;

    localparam int DIRECTED_ROWS = 40;

    // Directed frames. Typed results appear only on the last trailer byte of a frame.
    localparam t_row DIRECTED [DIRECTED_ROWS] = '{
        // Reset config: all-zero header/trailer, nine payload bytes
        '{ROW_BYTE, '0, 8'h00, 1'b0, '0},
        '{ROW_BYTE, '0, 8'h00, 1'b0, '0},
        '{ROW_BYTE, '0, 8'h00, 1'b0, '0},
        '{ROW_BYTE, '0, 8'hFF, 1'b0, '0},   // tag
        '{ROW_BYTE, '0, 8'h00, 1'b0, '0},
        '{ROW_BYTE, '0, 8'h00, 1'b0, '0},
        '{ROW_BYTE, '0, 8'hFF, 1'b0, '0},   // payload bytes 3..8, all ones
        '{ROW_BYTE, '0, 8'hFF, 1'b0, '0},
        '{ROW_BYTE, '0, 8'hFF, 1'b0, '0},
        '{ROW_BYTE, '0, 8'hFF, 1'b0, '0},
        '{ROW_BYTE, '0, 8'hFF, 1'b0, '0},
        '{ROW_BYTE, '0, 8'hFF, 1'b0, '0},
        '{ROW_BYTE, '0, 8'h00, 1'b0, '0},
        '{ROW_BYTE, '0, 8'h00, 1'b1, '{8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}},
        '{ROW_SETTLE, '0, 8'h00, 1'b0, '0},
        '{ROW_CFG, REG_HEADER_A,  8'hFF, 1'b0, '0},
        '{ROW_CFG, REG_HEADER_B,  8'h00, 1'b0, '0},
        '{ROW_CFG, REG_HEADER_C,  8'hFF, 1'b0, '0},
        '{ROW_CFG, REG_TRAILER_A, 8'h00, 1'b0, '0},
        '{ROW_CFG, REG_TRAILER_B, 8'hFF, 1'b0, '0},
        '{ROW_CFG, REG_LENGTH,    8'hC0, 1'b0, '0},   // length field 0, clamps up to 9
        '{ROW_CFG, CFG_SPARE_A,   8'h5A, 1'b0, '0},
        '{ROW_CFG, CFG_SPARE_B,   8'hA5, 1'b0, '0},
        // Second FF misses header B and must not restart the hunt as a first header
        '{ROW_BYTE, '0, 8'hFF, 1'b0, '0},
        '{ROW_BYTE, '0, 8'hFF, 1'b0, '0},
        '{ROW_BYTE, '0, 8'h00, 1'b0, '0},
        '{ROW_BYTE, '0, 8'hFF, 1'b0, '0},
        '{ROW_BYTE, '0, 8'h00, 1'b0, '0},
        '{ROW_BYTE, '0, 8'hFF, 1'b0, '0},
        '{ROW_BYTE, '0, 8'h00, 1'b0, '0},   // tag
        '{ROW_BYTE, '0, 8'h5A, 1'b0, '0},
        '{ROW_BYTE, '0, 8'hA5, 1'b0, '0},
        '{ROW_BYTE, '0, 8'h00, 1'b0, '0},
        '{ROW_BYTE, '0, 8'hFF, 1'b0, '0},
        '{ROW_BYTE, '0, 8'h00, 1'b0, '0},
        '{ROW_BYTE, '0, 8'hFF, 1'b0, '0},
        '{ROW_BYTE, '0, 8'h00, 1'b0, '0},
        '{ROW_BYTE, '0, 8'hFF, 1'b0, '0},
        '{ROW_BYTE, '0, 8'h00, 1'b0, '0},
        '{ROW_BYTE, '0, 8'hFF, 1'b1, '{8'h00, 16'hFF00, 16'hFF00, 16'hFF00}}
    };

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    rfp_stream_if #(.t_payload(t_rx_item)) rx_if ();
    rfp_stream_if #(.t_payload(t_result))  res_if ();

    ranging_frame_parser dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_rx        (rx_if),
        .o_result    (res_if)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Parser image: configuration and frame state kept alongside the block
    t_cfg       pred_cfg;
    t_phase     pred_phase;
    logic [5:0] pred_index;
    logic [7:0] pred_tag;
    logic [47:0] pred_ranges;

    t_result    frame_results_q[$];
    int         errors = 0;
    int         cycles = 0;
    int         sent_bytes = 0;
    bit         src_idling = 1'b1;
    bit         sink_idling = 1'b1;
    bit         long_hold_req = 1'b0;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time,
                     frame_results_q.size());
            $display("ranging_frame_parser_tb: FAIL");
            $finish;
        end
    end

    // Payload length in force: clamp the register into the legal window
    function automatic int frame_length();
        int len;
        len = int'(pred_cfg.payload_length);
        if (len < MIN_PAYLOAD) len = MIN_PAYLOAD;
        if (len > RFP_MAX_PAYLOAD) len = RFP_MAX_PAYLOAD;
        return len;
    endfunction

    // Advance the parser image by one byte; return 1 when a frame completes
    function automatic bit parse_byte(input logic [7:0] b, output t_result res);
        int idx;
        res = '0;
        parse_byte = 1'b0;
        case (pred_phase)
            PH_HEAD_B: begin
                pred_phase = (b == pred_cfg.header_byte_b) ? PH_HEAD_C : PH_HEAD_A;
            end
            PH_HEAD_C: begin
                pred_phase = (b == pred_cfg.header_byte_c) ? PH_PAYLOAD : PH_HEAD_A;
                pred_index = '0;
            end
            PH_PAYLOAD: begin
                idx = int'(pred_index);
                if (idx == TAG_POS) begin
                    pred_tag = b;
                end else if (idx >= RANGE_FIRST && idx <= RANGE_LAST) begin
                    pred_ranges[(idx - RANGE_FIRST) * 8 +: 8] = b;
                end
                idx++;
                // The length is read on every byte, so a mid-payload change applies to this frame
                if (idx >= frame_length()) begin
                    pred_phase = PH_TRAIL_A;
                    pred_index = '0;
                end else begin
                    pred_index = idx[5:0];
                end
            end
            PH_TRAIL_A: begin
                pred_phase = (b == pred_cfg.trailer_byte_a) ? PH_TRAIL_B : PH_HEAD_A;
            end
            PH_TRAIL_B: begin
                if (b == pred_cfg.trailer_byte_b) begin
                    res.tag_id      = pred_tag;
                    res.range_one   = pred_ranges[15:0];
                    res.range_two   = pred_ranges[31:16];
                    res.range_three = pred_ranges[47:32];
                    parse_byte = 1'b1;
                end
                pred_phase = PH_HEAD_A;
            end
            default: begin
                pred_phase = (b == pred_cfg.header_byte_a) ? PH_HEAD_B : PH_HEAD_A;
            end
        endcase
    endfunction

    // Offer one byte, hold it until taken, then predict. Entered and left at a clock edge.
    task automatic push_byte(input logic [7:0] b, input bit typed, input t_result want);
        t_result res;
        bit      done;
        if (src_idling && $urandom_range(0, 9) == 0) begin
            rx_if.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        rx_if.valid <= 1'b1;
        rx_if.payload.rx_byte <= b;
        @(posedge i_clk);
        while (!rx_if.ready) @(posedge i_clk);
        sent_bytes++;
        done = parse_byte(b, res);
        if (done || typed) frame_results_q.push_back(typed ? want : res);
    endtask

    // Drop valid and wait until every expected frame result has been seen
    task automatic wait_idle();
        rx_if.valid <= 1'b0;
        @(posedge i_clk);
        while (frame_results_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            REG_HEADER_A:  pred_cfg.header_byte_a  = data;
            REG_HEADER_B:  pred_cfg.header_byte_b  = data;
            REG_HEADER_C:  pred_cfg.header_byte_c  = data;
            REG_TRAILER_A: pred_cfg.trailer_byte_a = data;
            REG_TRAILER_B: pred_cfg.trailer_byte_b = data;
            REG_LENGTH:    pred_cfg.payload_length = data[LEN_W-1:0];
            default: ;
        endcase
    endtask

    // Send a frame built from the current config with random payload; optionally
    // break one header or trailer byte, and optionally stop partway through
    task automatic send_frame(input bit corrupt, input int stop_after);
        logic [7:0] seq[$];
        int         bad;
        seq = '{pred_cfg.header_byte_a, pred_cfg.header_byte_b, pred_cfg.header_byte_c};
        repeat (frame_length()) seq.push_back(8'($urandom_range(0, 255)));
        seq.push_back(pred_cfg.trailer_byte_a);
        seq.push_back(pred_cfg.trailer_byte_b);
        if (corrupt) begin
            bad = $urandom_range(0, 4);
            if (bad >= 3) bad = seq.size() - 5 + bad;
            seq[bad] = seq[bad] ^ 8'($urandom_range(1, 255));
        end
        foreach (seq[k]) begin
            if (k < stop_after) push_byte(seq[k], 1'b0, '0);
        end
    endtask

    // Result side: check each taken result against the oldest prediction,
    // then pick ready for the next cycle (random stalls, one long hold-off)
    initial begin : result_sink
        t_result want;
        t_result got;
        int      stall_left;
        stall_left = 0;
        res_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && res_if.valid && res_if.ready) begin
                got = res_if.payload;
                if (frame_results_q.size() == 0) begin
                    $display("%0t: unexpected result: expected none, ", $time,
                             "got tag %02h ranges %04h %04h %04h",
                             got.tag_id, got.range_one, got.range_two, got.range_three);
                    errors++;
                end else begin
                    want = frame_results_q.pop_front();
                    if (got.tag_id !== want.tag_id || got.range_one !== want.range_one ||
                        got.range_two !== want.range_two ||
                        got.range_three !== want.range_three) begin
                        $display("%0t: result mismatch: ", $time,
                                 "expected tag %02h ranges %04h %04h %04h, ",
                                 want.tag_id, want.range_one, want.range_two,
                                 want.range_three,
                                 "got tag %02h ranges %04h %04h %04h",
                                 got.tag_id, got.range_one, got.range_two,
                                 got.range_three);
                        errors++;
                    end
                end
            end
            if (stall_left != 0) begin
                stall_left--;
            end else if (long_hold_req) begin
                long_hold_req = 1'b0;
                stall_left = LONG_HOLD_CYCLES;
            end else if (sink_idling && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 14);
            end
            res_if.ready <= (stall_left == 0);
        end
    end

    initial begin : stimulus
        int         ph;
        int         phase_end;
        int         pick;
        int         len6;
        logic [7:0] hdr_a, hdr_b, hdr_c, trl_a, trl_b, len_byte;

        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        rx_if.valid = 1'b0;
        rx_if.payload = '0;

        pred_cfg = '0;
        pred_cfg.payload_length = LEN_W'(LENGTH_RESET);
        pred_phase  = PH_HEAD_A;
        pred_index  = '0;
        pred_tag    = '0;
        pred_ranges = '0;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < DIRECTED_ROWS; i++) begin
            case (DIRECTED[i].kind)
                ROW_SETTLE: wait_idle();
                ROW_CFG:    write_reg(DIRECTED[i].index, DIRECTED[i].value);
                default:    push_byte(DIRECTED[i].value, DIRECTED[i].typed, DIRECTED[i].want);
            endcase
        end

        for (ph = 0; ph < NUM_PHASES; ph++) begin
            wait_idle();
            if (ph == NUM_PHASES - 1) begin
                // Run the last phase at full rate on both sides
                src_idling  = 1'b0;
                sink_idling = 1'b0;
            end

            hdr_a = 8'($urandom_range(0, 255));
            hdr_b = ($urandom_range(0, 3) == 0) ? hdr_a : 8'($urandom_range(0, 255));
            hdr_c = 8'($urandom_range(0, 255));
            trl_a = 8'($urandom_range(0, 255));
            trl_b = 8'($urandom_range(0, 255));
            case ($urandom_range(0, 9))
                0:       len6 = $urandom_range(0, 8);
                1:       len6 = $urandom_range(33, 63);
                2:       len6 = $urandom_range(15, 32);
                default: len6 = $urandom_range(9, 14);
            endcase
            len_byte = 8'($urandom_range(0, 255));
            len_byte[5:0] = len6[5:0];
            if (ph == 0) begin
                {hdr_a, hdr_b, hdr_c, trl_a, trl_b} = '0;
                len_byte = 8'd9;
            end else if (ph == NUM_PHASES - 1) begin
                {hdr_a, hdr_b, hdr_c, trl_a, trl_b} = '1;
                len_byte = 8'hFF;
            end
            write_reg(REG_HEADER_A, hdr_a);
            write_reg(REG_HEADER_B, hdr_b);
            write_reg(REG_HEADER_C, hdr_c);
            write_reg(REG_TRAILER_A, trl_a);
            write_reg(REG_TRAILER_B, trl_b);
            write_reg(REG_LENGTH, len_byte);
            write_reg(CFG_SPARE_A, 8'($urandom_range(0, 255)));
            write_reg(CFG_SPARE_B, 8'($urandom_range(0, 255)));

            if (ph == 0) begin
                // Hold the result side off while good frames stream in back to back,
                // so the result buffer fills and the byte input stalls
                long_hold_req = 1'b1;
                src_idling = 1'b0;
                repeat (12) send_frame(1'b0, FULL_FRAME);
                src_idling = 1'b1;
            end

            phase_end = sent_bytes + PHASE_BYTES;
            while (sent_bytes < phase_end) begin
                pick = $urandom_range(0, 99);
                if (pick < 70) begin
                    send_frame(1'b0, FULL_FRAME);
                end else if (pick < 85) begin
                    send_frame(1'b1, FULL_FRAME);
                end else begin
                    // Line noise, sometimes carrying the first header byte
                    repeat ($urandom_range(1, 6)) begin
                        push_byte(($urandom_range(0, 3) == 0) ? pred_cfg.header_byte_a
                                                              : 8'($urandom_range(0, 255)),
                                  1'b0, '0);
                    end
                end
                if (ph != NUM_PHASES - 1 && $urandom_range(0, 29) == 0) wait_idle();
            end

            // Leave some phases partway through a frame so the next length write lands mid-frame
            if (ph != NUM_PHASES - 1 && $urandom_range(0, 1) == 0) begin
                send_frame(1'b0, $urandom_range(4, 12));
            end
        end

        wait_idle();
        if (errors == 0 && frame_results_q.size() == 0) begin
            $display("ranging_frame_parser_tb: PASS");
        end else begin
            $display("ranging_frame_parser_tb: FAIL");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/rfp_pkg.sv
rtl/rfp_stream_if.sv
rtl/rfp_cfg_regs.sv
rtl/rfp_frame_fsm.sv
rtl/rfp_out_buf.sv
rtl/ranging_frame_parser.sv
verif/ranging_frame_parser_tb.sv
